FILE: design/rational_arithmetic_unit_assert.svh
// Assertion macros used by the checker module of the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational arithmetic unit check failed");

// The consequent must hold in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational arithmetic unit check failed");

`endif

FILE: design/rau_pkg.sv
// Package with the request and response types and the codes of the rational arithmetic unit.
package rau_pkg;

    localparam int OPND_MAX = 32;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_DIV0 = 1'b1;

    // Operand fields are sized for the widest setting; only the low
    // OPERAND_WIDTH (numerator) or OPERAND_WIDTH-1 (denominator) bits are used.
    typedef struct packed {
        logic [2:0]            operation;
        logic [OPND_MAX-1:0]   a_num;
        logic [OPND_MAX-2:0]   a_den;
        logic [OPND_MAX-1:0]   b_num;
        logic [OPND_MAX-2:0]   b_den;
    } t_req;

    typedef struct packed {
        logic [31:0] res_num;
        logic [30:0] res_den;
        logic [1:0]  order;
        logic        status;
    } t_rsp;

endpackage

FILE: design/rau_mul.sv
// Shared signed multiplier with a registered product.
module rau_mul #(
    parameter int W = 16
) (
    input  logic                  i_clk,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_p
);

    logic signed [2*W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

FILE: design/rau_sub.sv
// Shared unsigned subtract and compare unit for the gcd and divide steps.
module rau_sub #(
    parameter int N = 33
) (
    input  logic [N-1:0] i_a,
    input  logic [N-1:0] i_b,
    output logic [N-1:0] o_diff,
    output logic         o_ge
);

    logic [N:0] full;

    assign full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = full[N-1:0];
    assign o_ge   = ~full[N];

endmodule

FILE: design/rational_arithmetic_unit.sv
// Compare and unused codes go from the products straight to the result; a zero numerator or
// a zero denominator stops after the sign step. Other operations run the cross products on the
// shared multiplier, a binary gcd through the shared subtractor, and two bit-serial divisions.
// Flow: one request at a time, taken in the cycle after the previous result is loaded; a
// result is loaded only when the output is empty or its held result is being taken.
// Reset: synchronous active-low reset returns the sequencer to idle and empties the output.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_req,
    output logic o_stall,
    output logic o_valid,
    output t_rsp o_rsp,
    input  logic i_stall
);

    localparam int W  = OPERAND_WIDTH;
    localparam int M  = 2 * W;
    localparam int CW = $clog2(M);
    localparam int XW = (M + 1 > 32) ? M + 1 : 32;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_COMB = 8'b0000_0100,
        S_ABS  = 8'b0000_1000,
        S_GCD  = 8'b0001_0000,
        S_DIVN = 8'b0010_0000,
        S_DIVD = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_valid, n_valid;

    logic [2:0] r_op, n_op;
    logic signed [W-1:0] r_an, n_an, r_bn, n_bn;
    logic [W-2:0] r_ad, n_ad, r_bd, n_bd;
    logic signed [M-1:0] r_p0, n_p0, r_p1, n_p1, r_p2, n_p2;
    logic signed [M:0] r_num, n_num;
    logic signed [M-1:0] r_den, n_den;
    logic [M-1:0] r_u, n_u, r_v, n_v, r_nm, n_nm, r_dm, n_dm, r_rem, n_rem;
    logic r_neg, n_neg;
    logic [1:0] r_ord, n_ord;
    logic r_err, n_err;
    t_rsp r_rsp, n_rsp;

    logic signed [W-1:0] mul_a, mul_b;
    logic signed [M-1:0] mul_p;
    logic [M:0] alu_a, alu_b, alu_diff, alu_neg;
    logic alu_ge;
    logic signed [M:0] num_abs, signed_q;
    logic signed [M-1:0] den_abs;
    logic signed [XW-1:0] num_ext;
    logic [XW-1:0] den_ext;

    rau_mul #(.W(W)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    rau_sub #(.N(M + 1)) u_sub (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_diff (alu_diff),
        .o_ge   (alu_ge)
    );

    assign alu_neg  = ~alu_diff + (M + 1)'(1);
    assign num_abs  = r_num[M] ? -r_num : r_num;
    assign den_abs  = r_den[M-1] ? -r_den : r_den;
    assign signed_q = r_neg ? -$signed({1'b0, r_nm}) : $signed({1'b0, r_nm});
    assign num_ext  = XW'(signed_q);
    assign den_ext  = XW'(r_dm);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        n_op    = r_op;
        n_an    = r_an;
        n_bn    = r_bn;
        n_ad    = r_ad;
        n_bd    = r_bd;
        n_p0    = r_p0;
        n_p1    = r_p1;
        n_p2    = r_p2;
        n_num   = r_num;
        n_den   = r_den;
        n_u     = r_u;
        n_v     = r_v;
        n_nm    = r_nm;
        n_dm    = r_dm;
        n_rem   = r_rem;
        n_neg   = r_neg;
        n_ord   = r_ord;
        n_err   = r_err;
        n_rsp   = r_rsp;
        mul_a   = r_an;
        mul_b   = $signed({1'b0, r_bd});
        alu_a   = {1'b0, r_u};
        alu_b   = {1'b0, r_v};

        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_req.operation;
                    n_an    = i_req.a_num[W-1:0];
                    n_bn    = i_req.b_num[W-1:0];
                    n_ad    = i_req.a_den[W-2:0];
                    n_bd    = i_req.b_den[W-2:0];
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                priority if (r_cnt == CW'(0)) begin
                    mul_a = r_an;
                    mul_b = (r_op == OP_MUL) ? r_bn : $signed({1'b0, r_bd});
                end else if (r_cnt == CW'(1)) begin
                    mul_a = $signed({1'b0, r_ad});
                    if (r_op == OP_DIV) begin
                        mul_b = r_bn;
                    end else if (r_op == OP_MUL) begin
                        mul_b = $signed({1'b0, r_bd});
                    end else begin
                        mul_a = r_bn;
                        mul_b = $signed({1'b0, r_ad});
                    end
                end else begin
                    mul_a = $signed({1'b0, r_ad});
                    mul_b = $signed({1'b0, r_bd});
                end
                if (r_cnt == CW'(1)) begin
                    n_p0 = mul_p;
                end
                if (r_cnt == CW'(2)) begin
                    n_p1 = mul_p;
                end
                if (r_cnt == CW'(3)) begin
                    n_p2    = mul_p;
                    n_state = S_COMB;
                end
                n_cnt = r_cnt + CW'(1);
            end
            S_COMB: begin
                n_ord = ORD_EQ;
                n_err = ST_OK;
                n_nm  = '0;
                n_dm  = M'(1);
                n_neg = 1'b0;
                unique case (r_op)
                    OP_ADD: begin
                        n_num   = (M + 1)'(r_p0) + (M + 1)'(r_p1);
                        n_den   = r_p2;
                        n_state = S_ABS;
                    end
                    OP_SUB: begin
                        n_num   = (M + 1)'(r_p0) - (M + 1)'(r_p1);
                        n_den   = r_p2;
                        n_state = S_ABS;
                    end
                    OP_MUL, OP_DIV: begin
                        n_num   = (M + 1)'(r_p0);
                        n_den   = r_p1;
                        n_state = S_ABS;
                    end
                    OP_CMP: begin
                        priority if (r_p0 < r_p1) begin
                            n_ord = ORD_LT;
                        end else if (r_p0 == r_p1) begin
                            n_ord = ORD_EQ;
                        end else begin
                            n_ord = ORD_GT;
                        end
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ABS: begin
                priority if (r_den == '0) begin
                    n_err   = ST_DIV0;
                    n_state = S_DONE;
                end else if (r_num == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_neg   = r_num[M] ^ r_den[M-1];
                    n_u     = num_abs[M-1:0];
                    n_nm    = num_abs[M-1:0];
                    n_v     = den_abs;
                    n_dm    = den_abs;
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                priority if (!r_u[0] && !r_v[0]) begin
                    n_u  = r_u >> 1;
                    n_v  = r_v >> 1;
                    n_nm = r_nm >> 1;
                    n_dm = r_dm >> 1;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (alu_diff == '0) begin
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIVN;
                end else if (alu_ge) begin
                    n_u = alu_diff[M:1];
                end else begin
                    n_v = alu_neg[M:1];
                end
            end
            S_DIVN: begin
                alu_a = {r_rem, r_nm[M-1]};
                alu_b = {1'b0, r_u};
                n_rem = alu_ge ? alu_diff[M-1:0] : alu_a[M-1:0];
                n_nm  = {r_nm[M-2:0], alu_ge};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(M - 1)) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                alu_a = {r_rem, r_dm[M-1]};
                alu_b = {1'b0, r_u};
                n_rem = alu_ge ? alu_diff[M-1:0] : alu_a[M-1:0];
                n_dm  = {r_dm[M-2:0], alu_ge};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(M - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_valid || !i_stall) begin
                    n_rsp.res_num = r_err ? 32'd0 : num_ext[31:0];
                    n_rsp.res_den = r_err ? 31'd1 : den_ext[30:0];
                    n_rsp.order   = r_ord;
                    n_rsp.status  = r_err;
                    n_valid       = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_an  <= n_an;
        r_bn  <= n_bn;
        r_ad  <= n_ad;
        r_bd  <= n_bd;
        r_p0  <= n_p0;
        r_p1  <= n_p1;
        r_p2  <= n_p2;
        r_num <= n_num;
        r_den <= n_den;
        r_u   <= n_u;
        r_v   <= n_v;
        r_nm  <= n_nm;
        r_dm  <= n_dm;
        r_rem <= n_rem;
        r_neg <= n_neg;
        r_ord <= n_ord;
        r_err <= n_err;
        r_rsp <= n_rsp;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

FILE: design/rau_checker.sv
// Port-level checker for the rational arithmetic unit and its bind statement.
`include "rational_arithmetic_unit_assert.svh"

module rau_checker
    import rau_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input t_req i_req,
    input logic o_stall,
    input logic o_valid,
    input t_rsp o_rsp,
    input logic i_stall
);

    // A response that is not taken stays in place.
    `RAU_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_rsp))

    // An accepted request keeps the unit busy in the following cycle.
    `RAU_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // A division by zero reports the fixed value zero over one.
    `RAU_ASSERT_NOW(a_err_value, i_clk, i_rst_n, o_valid && (o_rsp.status == ST_DIV0), (o_rsp.res_num == 32'd0) && (o_rsp.res_den == 31'd1) && (o_rsp.order == ORD_EQ))

    // A compare result other than equal carries no fraction and no error.
    `RAU_ASSERT_NOW(a_cmp_value, i_clk, i_rst_n, o_valid && (o_rsp.order != ORD_EQ), (o_rsp.res_num == 32'd0) && (o_rsp.res_den == 31'd1) && (o_rsp.status == ST_OK))

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

FILE: tb/rational_arithmetic_unit_tb.sv
// Self-checking testbench that drives directed and random fraction requests and checks every result.
module rational_arithmetic_unit_tb
    import rau_pkg::*;
();

    localparam int OPW          = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_SHOWN    = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_req i_req   = '0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    t_rsp o_rsp;

    t_rsp        want_q[$];
    t_req        asked_q[$];
    t_rsp        exp_rsp;
    t_req        exp_req;
    int unsigned mismatches = 0;
    int unsigned checked    = 0;
    int unsigned cycles     = 0;
    int unsigned stall_left = 0;
    int unsigned op_count[8];
    bit          idle_on    = 1'b1;

    rational_arithmetic_unit #(
        .OPERAND_WIDTH(OPW)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_req  (i_req),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_rsp  (o_rsp),
        .i_stall(i_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (want_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("unexpected result: num=%0d den=%0d order=%0d status=%0d",
                             $signed(o_rsp.res_num), o_rsp.res_den, o_rsp.order, o_rsp.status);
                end
            end else begin
                exp_rsp = want_q.pop_front();
                exp_req = asked_q.pop_front();
                checked++;
                if (o_rsp.res_num !== exp_rsp.res_num || o_rsp.res_den !== exp_rsp.res_den ||
                    o_rsp.order !== exp_rsp.order || o_rsp.status !== exp_rsp.status) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("mismatch op=%0d a=%0d/%0d b=%0d/%0d", exp_req.operation,
                                 $signed(exp_req.a_num[OPW-1:0]), exp_req.a_den[OPW-2:0],
                                 $signed(exp_req.b_num[OPW-1:0]), exp_req.b_den[OPW-2:0]);
                        $display("  expected num=%0d den=%0d order=%0d status=%0d",
                                 $signed(exp_rsp.res_num), exp_rsp.res_den, exp_rsp.order,
                                 exp_rsp.status);
                        $display("  actual   num=%0d den=%0d order=%0d status=%0d",
                                 $signed(o_rsp.res_num), o_rsp.res_den, o_rsp.order,
                                 o_rsp.status);
                    end
                end
            end
        end
    end

    function automatic longint euclid_gcd(input longint x, input longint y);
        longint rem;
        while (y != 0) begin
            rem = x % y;
            x   = y;
            y   = rem;
        end
        return x;
    endfunction

    function automatic t_rsp predict_rational(input t_req r);
        longint an, ad, bn, bd, num, den, lhs, rhs, mag, g, signed_res, rd;
        bit     neg;
        t_rsp   p;
        an = longint'($signed(r.a_num[OPW-1:0]));
        ad = longint'(r.a_den[OPW-2:0]);
        bn = longint'($signed(r.b_num[OPW-1:0]));
        bd = longint'(r.b_den[OPW-2:0]);
        p.res_num = '0;
        p.res_den = 31'd1;
        p.order   = ORD_EQ;
        p.status  = ST_OK;
        unique case (r.operation)
            OP_ADD: begin
                num = an * bd + bn * ad;
                den = ad * bd;
            end
            OP_SUB: begin
                num = an * bd - bn * ad;
                den = ad * bd;
            end
            OP_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            OP_DIV: begin
                num = an * bd;
                den = ad * bn;
            end
            OP_CMP: begin
                lhs = an * bd;
                rhs = bn * ad;
                p.order = (lhs < rhs) ? ORD_LT : ((lhs == rhs) ? ORD_EQ : ORD_GT);
                return p;
            end
            default: begin
                return p;
            end
        endcase
        if (den == 0) begin
            p.status = ST_DIV0;
            return p;
        end
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num == 0) begin
            return p;
        end
        neg        = num < 0;
        mag        = neg ? -num : num;
        g          = euclid_gcd(mag, den);
        signed_res = neg ? -(mag / g) : mag / g;
        rd         = den / g;
        p.res_num  = signed_res[31:0];
        p.res_den  = rd[30:0];
        return p;
    endfunction

    function automatic logic [31:0] place_num(input int v, input bit junk);
        logic [31:0] w;
        logic [31:0] noise;
        w = v;
        noise = $urandom;
        if (junk) begin
            w[31:OPW] = noise[31-OPW:0];
        end
        return w;
    endfunction

    function automatic logic [30:0] place_den(input int v, input bit junk);
        logic [31:0] w;
        logic [31:0] noise;
        w = v;
        noise = $urandom;
        if (junk) begin
            w[30:OPW-1] = noise[31-OPW:0];
        end
        return w[30:0];
    endfunction

    function automatic t_req frac_req(input logic [2:0] op, input int an, input int ad,
                                      input int bn, input int bd);
        t_req r;
        r.operation = op;
        r.a_num     = place_num(an, 1'b0);
        r.a_den     = place_den(ad, 1'b0);
        r.b_num     = place_num(bn, 1'b0);
        r.b_den     = place_den(bd, 1'b0);
        return r;
    endfunction

    function automatic int pick_num();
        int          v;
        int          lo;
        int          hi;
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0: v = -32768;
            1: v = 32767;
            2: v = 0;
            3, 4: begin
                lo = $urandom_range(0, 40);
                v  = lo - 20;
            end
            5, 6: begin
                lo = $urandom_range(0, 254);
                hi = $urandom_range(1, 256);
                v  = (lo - 127) * hi;
            end
            default: begin
                w = $urandom;
                v = $signed(w[15:0]);
            end
        endcase
        return v;
    endfunction

    function automatic int pick_den();
        int v;
        int lo;
        int hi;
        case ($urandom_range(0, 19))
            0: v = 0;
            1, 2: v = 32767;
            3: v = 1;
            4, 5, 6, 7: v = $urandom_range(1, 16);
            8, 9, 10, 11: begin
                lo = $urandom_range(1, 127);
                hi = $urandom_range(1, 256);
                v  = lo * hi;
            end
            default: v = $urandom_range(1, 32767);
        endcase
        return v;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int   an, ad, bn, bd, p, q, m, sel;
        bit   junk;
        sel  = $urandom_range(0, 39);
        junk = 1'($urandom_range(0, 1));
        if (sel == 0) begin
            r.operation = OP_CMP + 3'($urandom_range(1, 3));
        end else begin
            r.operation = 3'($urandom_range(OP_ADD, OP_CMP));
        end
        if ($urandom_range(0, 6) == 0) begin
            // Equal values written with different common factors.
            p  = $urandom_range(0, 200);
            p  = p - 100;
            q  = $urandom_range(1, 100);
            m  = $urandom_range(1, 300);
            an = p * m;
            ad = q * m;
            m  = $urandom_range(1, 300);
            bn = p * m;
            bd = q * m;
        end else begin
            an = pick_num();
            ad = pick_den();
            bn = pick_num();
            bd = pick_den();
        end
        r.a_num = place_num(an, junk);
        r.a_den = place_den(ad, junk);
        r.b_num = place_num(bn, junk);
        r.b_den = place_den(bd, junk);
        return r;
    endfunction

    task automatic send_req(input t_req r);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        want_q.push_back(predict_rational(r));
        asked_q.push_back(r);
        op_count[r.operation]++;
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (want_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_each_operation();
        send_req(frac_req(OP_ADD, 1, 2, 1, 3));
        send_req(frac_req(OP_SUB, 1, 2, 3, 4));
        send_req(frac_req(OP_MUL, -2, 3, 9, 4));
        send_req(frac_req(OP_DIV, 3, 5, -6, 7));
        send_req(frac_req(OP_CMP, 1, 3, 1, 2));
    endtask

    task automatic test_field_extremes();
        send_req(frac_req(OP_ADD, -32768, 32767, -32768, 32767));
        send_req(frac_req(OP_ADD, 32767, 1, 32767, 1));
        send_req(frac_req(OP_SUB, 32767, 1, -32768, 1));
        send_req(frac_req(OP_MUL, -32768, 1, -32768, 1));
        send_req(frac_req(OP_MUL, 32767, 32767, 1, 1));
        send_req(frac_req(OP_DIV, -32768, 1, -1, 32767));
        send_req(frac_req(OP_ADD, 0, 5, 0, 7));
    endtask

    task automatic test_division_by_zero();
        send_req(frac_req(OP_DIV, 5, 3, 0, 1));
        send_req(frac_req(OP_DIV, 0, 3, 0, 7));
        send_req(frac_req(OP_ADD, 1, 0, 1, 2));
        send_req(frac_req(OP_MUL, 2, 3, 4, 0));
        send_req(frac_req(OP_CMP, 1, 0, 1, 2));
    endtask

    task automatic test_compare();
        send_req(frac_req(OP_CMP, 2, 4, 1, 2));
        send_req(frac_req(OP_CMP, 5, 7, -5, 7));
        send_req(frac_req(OP_CMP, -32768, 1, 32767, 1));
        send_req(frac_req(OP_CMP, 32767, 32766, 32766, 32767));
    endtask

    task automatic test_unused_codes();
        int k;
        for (k = 1; k <= 3; k++) begin
            send_req(frac_req(OP_CMP + 3'(k), 7, 3, -2, 9));
        end
    endtask

    task automatic test_random_mixed(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 200 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            send_req(random_req());
        end
        idle_on = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        repeat (5) begin
            repeat (8) send_req(random_req());
            hold_until_drained();
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        repeat (count) send_req(random_req());
    endtask

    initial begin
        foreach (op_count[k]) op_count[k] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_each_operation();
        test_field_extremes();
        test_division_by_zero();
        test_compare();
        test_unused_codes();
        test_random_mixed(1430);
        test_pause_until_drained();
        test_back_to_back(250);
        i_valid <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d add, %0d subtract, %0d multiply, %0d divide, %0d compare requests",
                 op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV],
                 op_count[OP_CMP]);
        $display("and %0d with unused codes; %0d results checked, %0d mismatches.",
                 op_count[5] + op_count[6] + op_count[7], checked, mismatches);
        if (mismatches == 0 && want_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
